/* src/nssd_pkg.sv */
// ----------------------------------------------------------------------------
// nssd_pkg
// Shared types and constants for the noise shaped stereo dither block.
// ----------------------------------------------------------------------------
`default_nettype none

package nssd_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int FRAC_BITS     = 16;
    localparam int SHAPER_STAGES = 16;
    localparam int RECIP_EXTRA   = 11;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_RES = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEREZ    = 4'd1;

    localparam logic [31:0] SEED_INIT   = 32'h9E37_79B9;
    localparam logic [15:0] K_097       = 16'd63570;
    localparam logic [15:0] K_0475      = 16'd31130;
    localparam logic [39:0] K_MIN_SCALE = 40'd7;
    localparam logic [39:0] K_MIN_OUT   = 40'd524288;
    localparam logic [39:0] STEP_RESET  = 40'd2147483648;
    localparam logic [31:0] RECIP_RESET = 32'd524288;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } t_out_word;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MUL   = 13'b0000000000010,
        S_SCL   = 13'b0000000000100,
        S_DIV   = 13'b0000000001000,
        S_SHAPE = 13'b0000000010000,
        S_O0    = 13'b0000000100000,
        S_O1    = 13'b0000001000000,
        S_O2    = 13'b0000010000000,
        S_O3    = 13'b0000100000000,
        S_O4    = 13'b0001000000000,
        S_O5    = 13'b0010000000000,
        S_O6    = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } t_state;

endpackage

`default_nettype wire

/* src/noise_shaped_stereo_dither.sv */
// ----------------------------------------------------------------------------
// noise_shaped_stereo_dither
// Stereo requantizer: scaled sample plus shaped dither plus cubic error
// feedback, floored to a step and rescaled to Q1.23.
// ----------------------------------------------------------------------------
// Per channel, left then right: a shaper sweep over the state RAM, the
// feedback states S_O0 to S_O6 and the rescale state S_FIN. A new pair is
// accepted only in idle, once the previous pair is through; an output stall
// holds the block in S_FIN. The shaper RAM is swept serially (one stage
// read-modify-write per cycle). A config write holds the block through 6
// multiply, 1 scale and 51 divide steps. Reset (sync, active low) clears
// control, seed and scale; RAM reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module noise_shaped_stereo_dither
    import nssd_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  t_in_word                i_in_word,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output t_out_word               o_out_word,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0] i_cfg_data
);

    // saturate helpers
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647)       sat32 = 32'sh7FFF_FFFF;
        else if (v < -50'sd2147483648) sat32 = 32'sh8000_0000;
        else                           sat32 = v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [48:0] v);
        if (v > 49'sd8388607)       sat24 = 24'sh7F_FFFF;
        else if (v < -49'sd8388608) sat24 = 24'sh80_0000;
        else                        sat24 = v[23:0];
    endfunction

    // control
    t_state       r_state;
    logic [5:0]   r_cnt;
    logic         r_ch;          // 0 left, 1 right
    logic         r_high_res;
    logic [15:0]  r_derez;
    logic [31:0]  r_seed;
    logic [39:0]  r_step;
    logic [31:0]  r_recip;
    logic         r_out_vld;
    t_out_word    r_out_word;

    // config datapath
    logic [16:0]  r_p;
    logic [39:0]  r_div;
    logic [39:0]  r_rem;
    logic [31:0]  r_q;

    // channel datapath
    t_in_word                r_in;
    logic signed [44:0]      r_plo;
    logic signed [44:0]      r_phi;
    logic signed [40:0]      r_v;
    logic signed [25:0]      r_a;
    logic signed [31:0]      r_o;
    logic signed [31:0]      r_e;
    logic signed [31:0]      r_sq;
    logic signed [47:0]      r_cu;
    logic signed [48:0]      r_t3;
    logic signed [32:0]      r_ot;
    logic signed [26:0]      r_n;
    logic signed [23:0]      r_y_left;

    // shaper RAM: left stages at 0..15, right at 16..31
    logic [23:0]  sh_mem [32];
    logic [31:0]  r_sh_vld;
    logic [23:0]  r_sh_rd;
    logic         r_sh_rdv;
    logic [4:0]   sh_ra;
    logic [4:0]   sh_wa;
    logic         sh_we;
    logic [23:0]  sh_wd;

    // per-channel feedback RAM: {odd, err}
    logic [63:0]  cm_mem [2];
    logic [1:0]   r_cm_vld;
    logic [63:0]  r_cm_rd;
    logic         r_cm_rdv;
    logic         cm_we;
    logic [63:0]  cm_wd;

    // combinational terms
    logic [31:0]         seed_nx;
    logic signed [15:0]  draw;
    logic signed [25:0]  sh_old;
    logic signed [26:0]  sh_sum;
    logic signed [25:0]  sh_new;
    logic signed [25:0]  a_acc;
    logic signed [25:0]  a_next;
    logic signed [23:0]  x_sel;
    logic signed [65:0]  v_sum;
    logic signed [31:0]  o_pre;
    logic signed [31:0]  o_fold;
    logic signed [63:0]  p_sq;
    logic signed [63:0]  p_cu;
    logic signed [64:0]  p_t3;
    logic signed [31:0]  o_cub;
    logic signed [31:0]  o_fb;
    logic signed [48:0]  p_ot;
    logic signed [42:0]  t_sum;
    logic signed [43:0]  e_raw;
    logic signed [59:0]  p_y;
    logic signed [23:0]  y_sat;
    logic [33:0]         p_mul;
    logic [16:0]         u_fac;
    logic [39:0]         step_nx;
    logic [50:0]         num;
    logic [40:0]         rem_sh;
    logic                q_bit;

    // a pending config write takes the idle slot, so the input word waits
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    always_comb begin
        // config: p = (p*u) >> 16, then divide for the reciprocal
        u_fac   = 17'd65536 - {1'b0, r_derez};
        p_mul   = r_p * u_fac;
        step_nx = r_high_res ? ({23'd0, r_p} << 23) : ({23'd0, r_p} << 15);
        if (step_nx < K_MIN_SCALE) begin
            step_nx = K_MIN_SCALE;
        end
        num    = (51'd1 << 50) + {12'd0, r_div[39:1]};
        rem_sh = {r_rem, num[r_cnt]};
        q_bit  = (rem_sh >= {1'b0, r_div});

        // dither draw from xorshift32
        seed_nx = r_seed ^ (r_seed << 13);
        seed_nx = seed_nx ^ (seed_nx >> 17);
        seed_nx = seed_nx ^ (seed_nx << 5);
        draw    = $signed({~seed_nx[31], seed_nx[30:16]});

        // one half-averaging stage
        sh_old = r_sh_rdv ? 26'(signed'(r_sh_rd)) : 26'sd0;
        a_acc  = r_a + 26'(draw);
        sh_sum = 27'(sh_old) + 27'(a_acc);
        sh_new = sh_sum[26:1];
        a_next = a_acc - sh_new;

        // scaled sample v = (x*step) >> 23, split multiply
        x_sel = r_ch ? r_in.right_sample : r_in.left_sample;
        v_sum = (66'(r_phi) <<< 20) + 66'(r_plo);

        // odd term
        o_pre  = (r_o > 32'sd0) ? (r_o - 32'(signed'({1'b0, K_097}))) : r_o;
        o_fold = (o_pre < 32'sd0) ? (o_pre + 32'(signed'({1'b0, K_097}))) : o_pre;
        p_sq   = 64'(r_o) * 64'(r_o);
        p_cu   = 64'(r_sq) * 64'(r_o);
        p_t3   = 65'(r_cu) * 65'(signed'({1'b0, K_0475}));
        o_cub  = sat32(50'(r_o) - 50'(r_t3));
        o_fb   = sat32(50'(o_cub) + 50'(r_e));
        p_ot   = 49'(r_o) * 49'(signed'({1'b0, K_0475}));

        // floor to a step, error and rescale
        t_sum = 43'(r_a) + 43'(r_v) + 43'(r_ot);
        e_raw = 44'(signed'({t_sum[42:16], 16'd0})) - 44'(r_v);
        p_y   = 60'(r_n) * 60'(signed'({1'b0, r_recip}));
        y_sat = sat24(p_y[59:11]);

        // RAM ports
        sh_ra = {r_ch, r_cnt[3:0]};
        sh_wa = {r_ch, r_cnt[3:0] - 4'd1};
        sh_we = (r_state == S_SHAPE) && (r_cnt != 6'd0);
        sh_wd = sh_new[23:0];
        cm_we = (r_state == S_O6);
        cm_wd = {r_o, sat32(50'(e_raw))};
    end

    // RAM arrays
    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            sh_mem[sh_wa] <= sh_wd;
        end
        r_sh_rd <= sh_mem[sh_ra];
        if (cm_we) begin
            cm_mem[r_ch] <= cm_wd;
        end
        r_cm_rd <= cm_mem[r_ch];
    end

    // valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_vld <= '0;
            r_cm_vld <= '0;
            r_sh_rdv <= 1'b0;
            r_cm_rdv <= 1'b0;
        end else begin
            if (sh_we) begin
                r_sh_vld[sh_wa] <= 1'b1;
            end
            if (cm_we) begin
                r_cm_vld[r_ch] <= 1'b1;
            end
            r_sh_rdv <= r_sh_vld[sh_ra];
            r_cm_rdv <= r_cm_vld[r_ch];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_in <= i_in_word;
                end
                r_p <= 17'd65536;
            end
            S_MUL: begin
                r_p <= p_mul[32:16];
            end
            S_SCL: begin
                r_div <= (step_nx < K_MIN_OUT) ? K_MIN_OUT : step_nx;
                r_rem <= '0;
            end
            S_DIV: begin
                r_rem <= q_bit ? 40'(rem_sh - {1'b0, r_div}) : rem_sh[39:0];
                r_q   <= {r_q[30:0], q_bit};
            end
            S_SHAPE: begin
                r_a <= (r_cnt == 6'd0) ? 26'sd0 : a_next;
                if (r_cnt == 6'd0) begin
                    r_plo <= x_sel * $signed({1'b0, r_step[19:0]});
                    r_phi <= x_sel * $signed({1'b0, r_step[39:20]});
                end
                if (r_cnt == 6'd1) begin
                    r_o <= r_cm_rdv ? $signed(r_cm_rd[63:32]) : 32'sd0;
                    r_e <= r_cm_rdv ? $signed(r_cm_rd[31:0]) : 32'sd0;
                    r_v <= v_sum[63:23];
                end
            end
            S_O0: r_o  <= o_fold;
            S_O1: r_sq <= sat32(50'(p_sq[63:16]));
            S_O2: r_cu <= p_cu[63:16];
            S_O3: r_t3 <= p_t3[64:16];
            S_O4: r_o  <= o_fb;
            S_O5: r_ot <= p_ot[48:16];
            S_O6: r_n  <= t_sum[42:16];
            S_FIN: begin
                if (!r_ch) begin
                    r_y_left <= y_sat;
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_ch       <= 1'b0;
            r_high_res <= 1'b0;
            r_derez    <= '0;
            r_seed     <= SEED_INIT;
            r_step     <= STEP_RESET;
            r_recip    <= RECIP_RESET;
            r_out_vld  <= 1'b0;
        end else begin
            // load on the right channel's last cycle, else drain when taken
            if (r_state == S_FIN && r_ch && (!r_out_vld || !i_out_stall)) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    r_ch  <= 1'b0;
                    if (i_cfg_valid) begin
                        if (i_cfg_index == CFG_HIGH_RES) begin
                            r_high_res <= i_cfg_data[0];
                            r_state    <= S_MUL;
                        end else if (i_cfg_index == CFG_DEREZ) begin
                            r_derez <= i_cfg_data;
                            r_state <= S_MUL;
                        end
                    end else if (i_in_valid) begin
                        r_state <= S_SHAPE;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd5) begin
                        r_state <= S_SCL;
                    end
                end
                S_SCL: begin
                    r_step  <= step_nx;
                    r_cnt   <= 6'd50;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_recip <= {r_q[30:0], q_bit};
                        r_state <= S_IDLE;
                    end
                end
                S_SHAPE: begin
                    if (r_cnt != 6'd0) begin
                        r_seed <= seed_nx;
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(SHAPER_STAGES)) begin
                        r_state <= S_O0;
                    end
                end
                S_O0: r_state <= S_O1;
                S_O1: r_state <= S_O2;
                S_O2: r_state <= S_O3;
                S_O3: r_state <= S_O4;
                S_O4: r_state <= S_O5;
                S_O5: r_state <= S_O6;
                S_O6: r_state <= S_FIN;
                S_FIN: begin
                    r_cnt <= '0;
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_state <= S_SHAPE;
                    end else if (!r_out_vld || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && r_ch && (!r_out_vld || !i_out_stall)) begin
            r_out_word.left_out  <= r_y_left;
            r_out_word.right_out <= y_sat;
        end
    end

endmodule

`default_nettype wire
